### hw/rtl/ophp_pkg.sv
// Shared types and codes for the OpenPGP packet header parser.
// Used by ophp_parse, ophp_out_reg, the top and ophp_checker; depends on nothing else.
`timescale 1ns / 1ps

package ophp_pkg;

  // kind field of a result transaction
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  // length_format codes
  localparam logic [2:0] FMT_OLD      = 3'd0;
  localparam logic [2:0] FMT_NEW_ONE  = 3'd1;
  localparam logic [2:0] FMT_NEW_TWO  = 3'd2;
  localparam logic [2:0] FMT_NEW_FIVE = 3'd3;
  localparam logic [2:0] FMT_PARTIAL  = 3'd4;

  // error codes
  localparam logic [1:0] ERR_NONE          = 2'd0;
  localparam logic [1:0] ERR_NO_MARKER     = 2'd1;
  localparam logic [1:0] ERR_INDETERMINATE = 2'd2;

  // old-format length type that has no length bytes
  localparam logic [1:0] OLD_LEN_INDETERMINATE = 2'd3;

  // new-format first length byte boundaries
  localparam logic [7:0] NEW_TWO_MIN     = 8'd192;
  localparam logic [7:0] NEW_PARTIAL_MIN = 8'd224;
  localparam logic [7:0] NEW_FIVE_CODE   = 8'd255;

  // tdata packing
  localparam int unsigned TDATA_W = 56;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [5:0]  tag;
    logic [31:0] body_length;
    logic [2:0]  length_format;
    logic [7:0]  body_byte;
    logic        last;
    logic [1:0]  error;
  } result_t;

endpackage

### hw/rtl/ophp_in_reg.sv
// Input register for the byte stream.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps

module ophp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       take,      // parser consumes the held byte this cycle
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // space when empty or when the held byte leaves this cycle
  assign in_ready = !held_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

endmodule

### hw/rtl/ophp_parse.sv
// Packet header and length decode: parser state and one-byte step logic.
// Depends on ophp_pkg.
`timescale 1ns / 1ps

module ophp_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,      // a byte is consumed this cycle
  input  logic [7:0]        data_byte,
  output logic              res_valid,
  output ophp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NEW_LEN,
    PH_NEW_TWO,
    PH_NEW_FIVE,
    PH_OLD_LEN,
    PH_BODY
  } phase_t;

  phase_t      phase, phase_next;
  logic [5:0]  packet_tag, packet_tag_next;
  logic [2:0]  length_bytes_left, length_bytes_left_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [31:0] body_bytes_left, body_bytes_left_next;

  // header completion request
  logic        done;
  logic [31:0] done_len;
  logic [2:0]  done_fmt;
  logic [2:0]  bytes_dec;
  logic [31:0] acc_shift;

  // one step of the byte parser
  always_comb begin
    phase_next              = phase;
    packet_tag_next         = packet_tag;
    length_bytes_left_next  = length_bytes_left;
    length_accumulator_next = length_accumulator;
    body_bytes_left_next    = body_bytes_left;
    res_valid               = 1'b0;
    res                     = '0;
    done                    = 1'b0;
    done_len                = '0;
    done_fmt                = ophp_pkg::FMT_OLD;
    bytes_dec               = length_bytes_left - 3'd1;
    acc_shift               = {length_accumulator[23:0], data_byte};

    unique case (phase)
      PH_HEADER: begin
        if (!data_byte[7]) begin
          res_valid = 1'b1;
          res.error = ophp_pkg::ERR_NO_MARKER;
        end else if (data_byte[6]) begin
          packet_tag_next = data_byte[5:0];
          phase_next      = PH_NEW_LEN;
        end else begin
          packet_tag_next = {2'b00, data_byte[5:2]};
          if (data_byte[1:0] == ophp_pkg::OLD_LEN_INDETERMINATE) begin
            res_valid = 1'b1;
            res.tag   = {2'b00, data_byte[5:2]};
            res.error = ophp_pkg::ERR_INDETERMINATE;
          end else begin
            length_bytes_left_next  = 3'd1 << data_byte[1:0];
            length_accumulator_next = '0;
            phase_next              = PH_OLD_LEN;
          end
        end
      end
      PH_NEW_LEN: begin
        if (data_byte < ophp_pkg::NEW_TWO_MIN) begin
          done     = 1'b1;
          done_len = {24'd0, data_byte};
          done_fmt = ophp_pkg::FMT_NEW_ONE;
        end else if (data_byte < ophp_pkg::NEW_PARTIAL_MIN) begin
          length_accumulator_next = {19'd0, data_byte[4:0], 8'd0};
          length_bytes_left_next  = 3'd1;
          phase_next              = PH_NEW_TWO;
        end else if (data_byte != ophp_pkg::NEW_FIVE_CODE) begin
          done     = 1'b1;
          done_len = 32'd1 << data_byte[4:0];
          done_fmt = ophp_pkg::FMT_PARTIAL;
        end else begin
          length_accumulator_next = '0;
          length_bytes_left_next  = 3'd4;
          phase_next              = PH_NEW_FIVE;
        end
      end
      PH_NEW_TWO: begin
        done     = 1'b1;
        done_len = length_accumulator + {24'd0, data_byte}
                   + {24'd0, ophp_pkg::NEW_TWO_MIN};
        done_fmt = ophp_pkg::FMT_NEW_TWO;
      end
      PH_NEW_FIVE, PH_OLD_LEN: begin
        length_accumulator_next = acc_shift;
        if (length_bytes_left != 3'd0) begin
          length_bytes_left_next = bytes_dec;
        end
        if (length_bytes_left <= 3'd1) begin
          done     = 1'b1;
          done_len = acc_shift;
          done_fmt = (phase == PH_NEW_FIVE) ? ophp_pkg::FMT_NEW_FIVE
                                            : ophp_pkg::FMT_OLD;
        end
      end
      PH_BODY: begin
        res_valid     = 1'b1;
        res.kind      = ophp_pkg::KIND_BODY;
        res.tag       = packet_tag;
        res.body_byte = data_byte;
        if (body_bytes_left <= 32'd1) begin
          body_bytes_left_next = '0;
          phase_next           = PH_HEADER;
          res.last             = 1'b1;
        end else begin
          body_bytes_left_next = body_bytes_left - 32'd1;
        end
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // header result once the length is complete
    if (done) begin
      length_bytes_left_next  = '0;
      length_accumulator_next = done_len;
      body_bytes_left_next    = done_len;
      phase_next              = (done_len == 32'd0) ? PH_HEADER : PH_BODY;
      res_valid               = 1'b1;
      res.kind                = ophp_pkg::KIND_HEADER;
      res.tag                 = packet_tag;
      res.body_length         = done_len;
      res.length_format       = done_fmt;
      res.last                = (done_len == 32'd0);
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      packet_tag         <= '0;
      length_bytes_left  <= '0;
      length_accumulator <= '0;
      body_bytes_left    <= '0;
    end else if (step) begin
      phase              <= phase_next;
      packet_tag         <= packet_tag_next;
      length_bytes_left  <= length_bytes_left_next;
      length_accumulator <= length_accumulator_next;
      body_bytes_left    <= body_bytes_left_next;
    end
  end

endmodule

### hw/rtl/ophp_out_reg.sv
// Result register in front of the master-side stream.
// Depends on ophp_pkg.
`timescale 1ns / 1ps

module ophp_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ophp_pkg::result_t load_res,
  output logic              space,     // can take a result this cycle
  output logic              out_valid,
  input  logic              out_ready,
  output ophp_pkg::result_t out_res
);

  assign space = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (space && load) begin
      out_res <= load_res;
    end
  end

endmodule

### hw/rtl/openpgp_packet_header_parser.sv
// Channel   | Dir | Signals                              | Contents
// s_axis    | in  | tvalid tready tdata[7:0]             | data_byte
// m_axis    | out | tvalid tready tdata[55:0] tuser tlast | one parser result
//
// One byte per cycle sustained while m_axis_tready is high; a byte goes
// input register -> parse step -> result register, and its result shows
// on m_axis once the result register is loaded. The parse step over the
// 32-bit length state is combinational between the two registers.
// Body bytes and the last length byte give one result each; a header byte gives one only on an error.
// rst is synchronous and clears the parser to expect a header byte.
// A stall on m_axis holds the result register and backs up into s_axis.
// Depends on ophp_pkg, ophp_in_reg, ophp_parse, ophp_out_reg.
`timescale 1ns / 1ps

module openpgp_packet_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] tag, [37:6] body_length, [40:38] length_format,
  // [48:41] body_byte, [50:49] error, [55:51] zero
  output logic [ophp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast    // last
);

  logic              held_valid;
  logic [7:0]        held_byte;
  logic              space;
  logic              step;
  logic              res_valid;
  ophp_pkg::result_t res;
  ophp_pkg::result_t out_res;

  // a held byte is parsed when the result register has room
  assign step = held_valid && space;

  ophp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .take       (step),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  ophp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (held_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ophp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .load_res  (res),
    .space     (space),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // pack the result onto the stream
  assign m_axis_tdata = {5'd0, out_res.error, out_res.body_byte,
                         out_res.length_format, out_res.body_length, out_res.tag};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

endmodule

### hw/rtl/ophp_checker.sv
// Port-level checks for the OpenPGP packet header parser, bound to the top.
// Depends on ophp_pkg and openpgp_packet_header_parser.
`timescale 1ns / 1ps

module ophp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled result transaction keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // body transactions carry no length, format or error
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ophp_pkg::KIND_BODY |->
      m_axis_tdata[40:6] == 35'd0 && m_axis_tdata[50:49] == ophp_pkg::ERR_NONE)
    else $error("body transaction with header fields");

  // error headers never close a packet
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ophp_pkg::KIND_HEADER
      && m_axis_tdata[50:49] != ophp_pkg::ERR_NONE |->
      !m_axis_tlast)
    else $error("error header marked last");

  // missing header marker reports tag zero
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[50:49] == ophp_pkg::ERR_NO_MARKER |->
      m_axis_tdata[5:0] == 6'd0)
    else $error("marker error with nonzero tag");

  // a header marked last has zero body length
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ophp_pkg::KIND_HEADER && m_axis_tlast |->
      m_axis_tdata[37:6] == 32'd0)
    else $error("last header with body");

endmodule

bind openpgp_packet_header_parser ophp_checker u_ophp_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
